// File: src/lct_pkg.sv
// ----------------------------------------------------------------------------
// lct_pkg
// Shared command codes, rule constants and the cell update rule for the
// toroidal life block.
// ----------------------------------------------------------------------------
package lct_pkg;

  // Command codes carried on the command port.
  localparam logic [2:0] CMD_SET    = 3'd0;
  localparam logic [2:0] CMD_TOGGLE = 3'd1;
  localparam logic [2:0] CMD_CLEAR  = 3'd2;
  localparam logic [2:0] CMD_STEP   = 3'd3;
  localparam logic [2:0] CMD_READ   = 3'd4;

  // Neighbor counts of the life rule.
  localparam logic [3:0] LIFE_SURVIVE = 4'd2;
  localparam logic [3:0] LIFE_BIRTH   = 4'd3;

  // A live cell survives with two or three neighbors; a dead one is born
  // with exactly three.
  function automatic logic life_rule(input logic alive, input logic [3:0] count);
    life_rule = (count == LIFE_BIRTH) || (alive && (count == LIFE_SURVIVE));
  endfunction

endpackage

// File: src/lct_grid_mem.sv
// ----------------------------------------------------------------------------
// lct_grid_mem
// Row-word memory of the grid: one write port and one read port with
// registered read data.
// ----------------------------------------------------------------------------
module lct_grid_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// File: src/lct_row_unit.sv
// ----------------------------------------------------------------------------
// lct_row_unit
// Computes the next generation of one row from the old rows above, at and
// below it, all columns in parallel, with the columns wrapping around.
// ----------------------------------------------------------------------------
module lct_row_unit
  import lct_pkg::*;
#(
  parameter int COLS = 64
) (
  input  logic [COLS-1:0] row_up,
  input  logic [COLS-1:0] row_mid,
  input  logic [COLS-1:0] row_dn,
  output logic [COLS-1:0] row_new
);

  // One neighbor counter and rule per column.
  for (genvar c = 0; c < COLS; c++) begin : g_col
    localparam int Lf = (c == 0) ? COLS - 1 : c - 1;
    localparam int Rt = (c == COLS - 1) ? 0 : c + 1;
    logic [3:0] count;

    assign count = 4'(row_up[Lf]) + 4'(row_up[c]) + 4'(row_up[Rt])
                 + 4'(row_mid[Lf]) + 4'(row_mid[Rt])
                 + 4'(row_dn[Lf]) + 4'(row_dn[c]) + 4'(row_dn[Rt]);
    assign row_new[c] = life_rule(row_mid[c], count);
  end

endmodule

// File: src/life_cellular_automaton_torus_core.sv
// ----------------------------------------------------------------------------
// life_cellular_automaton_torus_core
// Toroidal game-of-life grid with set, toggle, clear, read and step commands.
// ----------------------------------------------------------------------------
// A command is taken at a rising edge where start is high and busy is low.
// Its one result appears on cell_state and applied for exactly one cycle,
// marked by done; the receiver cannot hold it off, so it must be taken then.
// run_enabled is written through cfg_valid/cfg_ready/cfg_data; cfg_ready is
// always high. Writes must be made only while the block is idle; the block
// itself does not enforce this. Steps of each command:
//   set, toggle, read: memory read, then modify and write back (not for read).
//   step: once the three-row window is filled, one row word goes through the
//     shared row unit per cycle, reading the grid memory on its single read
//     port.
//   clear: one row word zeroed per cycle.
//   blocked, out-of-range or unknown commands: done without leaving idle.
// busy stays high while a carried-out command is in work and low for blocked,
// out-of-range or unknown ones; one command is handled at a time. After reset
// the block runs a clearing pass over the whole grid memory with busy high and
// no result; configuration transfers are taken during it as ever.
// ----------------------------------------------------------------------------
module life_cellular_automaton_torus_core
  import lct_pkg::*;
#(
  parameter int GRID_ROWS = 64,
  parameter int GRID_COLS = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] command,
  input  logic [5:0] row,
  input  logic [5:0] column,
  input  logic       value,
  output logic       done,
  output logic       cell_state,
  output logic       applied,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);

  localparam int RW  = $clog2(GRID_ROWS);
  localparam int CLW = $clog2(GRID_COLS);
  localparam int CNW = $clog2(GRID_ROWS + 3);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RMW   = 2'd1;
  localparam logic [1:0] ST_STEP  = 2'd2;
  localparam logic [1:0] ST_CLEAR = 2'd3;

  localparam logic [CNW-1:0] CNT_FIRST_WR = CNW'(3);
  localparam logic [CNW-1:0] CNT_SAVE0    = CNW'(2);
  localparam logic [CNW-1:0] CNT_LAST_RD  = CNW'(GRID_ROWS + 1);
  localparam logic [CNW-1:0] CNT_STEP_END = CNW'(GRID_ROWS + 2);
  localparam logic [CNW-1:0] CNT_CLR_END  = CNW'(GRID_ROWS - 1);
  localparam logic [RW-1:0]  ROW_LAST     = RW'(GRID_ROWS - 1);

  // Control registers.
  logic [1:0]     state;
  logic [CNW-1:0] cnt;
  logic           clr_report;
  logic           run_enabled;

  // Payload registers.
  logic [2:0]           cmd_q;
  logic [RW-1:0]        row_q;
  logic [CLW-1:0]       col_q;
  logic                 val_q;
  logic [GRID_COLS-1:0] win_up;
  logic [GRID_COLS-1:0] win_mid;
  logic [GRID_COLS-1:0] row0_save;

  // Memory and row unit connections.
  logic                 wr_en;
  logic [RW-1:0]        wr_addr;
  logic [GRID_COLS-1:0] wr_data;
  logic [RW-1:0]        rd_addr;
  logic [GRID_COLS-1:0] rd_data;
  logic [GRID_COLS-1:0] win_dn;
  logic [GRID_COLS-1:0] row_new;
  logic [GRID_COLS-1:0] rmw_word;
  logic [GRID_COLS-1:0] col_mask;
  logic [CNW-1:0]       cnt_m1;
  logic [CNW-1:0]       cnt_m3;
  logic                 in_grid;
  logic                 accept;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign in_grid   = (32'(row) < GRID_ROWS) && (32'(column) < GRID_COLS);
  assign cnt_m1    = cnt - CNW'(1);
  assign cnt_m3    = cnt - CNT_FIRST_WR;

  // The last row wraps to the saved old row zero as its lower neighbor.
  assign win_dn = (cnt == CNT_STEP_END) ? row0_save : rd_data;

  lct_grid_mem #(
    .DEPTH(GRID_ROWS),
    .WIDTH(GRID_COLS)
  ) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  lct_row_unit #(
    .COLS(GRID_COLS)
  ) u_row (
    .row_up (win_up),
    .row_mid(win_mid),
    .row_dn (win_dn),
    .row_new(row_new)
  );

  // Read-modify-write of one cell in the addressed row word.
  always_comb begin
    col_mask = GRID_COLS'(1) << col_q;
    rmw_word = rd_data;
    case (cmd_q)
      CMD_SET:    rmw_word = val_q ? (rd_data | col_mask) : (rd_data & ~col_mask);
      CMD_TOGGLE: rmw_word = rd_data ^ col_mask;
      default:    rmw_word = rd_data;
    endcase
  end

  // Memory port steering for each state.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt_m3[RW-1:0];
    wr_data = row_new;
    rd_addr = RW'(row);
    case (state)
      ST_RMW: begin
        wr_en   = (cmd_q == CMD_SET) || (cmd_q == CMD_TOGGLE);
        wr_addr = row_q;
        wr_data = rmw_word;
      end
      ST_STEP: begin
        rd_addr = (cnt == '0) ? ROW_LAST : cnt_m1[RW-1:0];
        wr_en   = (cnt >= CNT_FIRST_WR);
      end
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = cnt[RW-1:0];
        wr_data = '0;
      end
      default: begin
        rd_addr = RW'(row);
      end
    endcase
  end

  // Sequencer and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      cnt         <= '0;
      clr_report  <= 1'b0;
      run_enabled <= 1'b0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        run_enabled <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          cnt <= '0;
          if (accept) begin
            case (command)
              CMD_SET, CMD_TOGGLE, CMD_READ: begin
                if (in_grid) begin
                  state <= ST_RMW;
                end else begin
                  done <= 1'b1;
                end
              end
              CMD_CLEAR: begin
                if (!run_enabled) begin
                  state      <= ST_CLEAR;
                  clr_report <= 1'b1;
                end else begin
                  done <= 1'b1;
                end
              end
              CMD_STEP: begin
                if (run_enabled) begin
                  state <= ST_STEP;
                end else begin
                  done <= 1'b1;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        ST_RMW: begin
          state <= ST_IDLE;
          done  <= 1'b1;
        end
        ST_STEP: begin
          cnt <= cnt + CNW'(1);
          if (cnt == CNT_STEP_END) begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end
        end
        ST_CLEAR: begin
          cnt <= cnt + CNW'(1);
          if (cnt == CNT_CLR_END) begin
            state      <= ST_IDLE;
            done       <= clr_report;
            clr_report <= 1'b0;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Command capture, row window and result values.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q      <= command;
      row_q      <= RW'(row);
      col_q      <= CLW'(column);
      val_q      <= value;
      cell_state <= 1'b0;
      applied    <= 1'b0;
      case (command)
        CMD_CLEAR: applied <= !run_enabled;
        CMD_STEP:  applied <= run_enabled;
        default:   applied <= 1'b0;
      endcase
    end
    if (state == ST_RMW) begin
      cell_state <= rmw_word[col_q];
      applied    <= 1'b1;
    end
    // The window shifts down one old row for each read word that arrives.
    if (state == ST_STEP && cnt != '0 && cnt <= CNT_LAST_RD) begin
      win_up  <= win_mid;
      win_mid <= rd_data;
    end
    if (state == ST_STEP && cnt == CNT_SAVE0) begin
      row0_save <= rd_data;
    end
  end

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the toroidal life block. A short table of commands
// drives the extremes, every command code, the blocked and wrapping cases, and
// is followed by random commands. These mostly land near a moving spot and
// mix cell writes, reads, steps, clears and unknown codes, over several
// run_enabled settings. Each result is checked against the table row where
// it gives one, else against a local copy of the grid updated per command.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lct_pkg::*;

  localparam int ROWS         = 64;
  localparam int COLS         = 64;
  localparam int RANDOM_ITEMS = 1300;
  localparam int PHASES       = 8;
  localparam int STEP_CYCLES  = ROWS + 4;

  // Codes outside the command set; the block must ignore them.
  localparam logic [2:0] CMD_BAD_5 = 3'd5;
  localparam logic [2:0] CMD_BAD_6 = 3'd6;
  localparam logic [2:0] CMD_BAD_7 = 3'd7;

  typedef enum logic { DO_COMMAND, DO_CONFIG } row_kind_t;

  // One row of the directed table. For DO_CONFIG rows, value is the new
  // run_enabled setting. When typed is set, the expected result is taken
  // from the row instead of the grid model.
  typedef struct packed {
    row_kind_t  kind;
    logic [2:0] cmd;
    logic [5:0] r;
    logic [5:0] c;
    logic       v;
    logic       typed;
    logic       exp_state;
    logic       exp_applied;
  } script_row_t;

  typedef struct packed {
    logic cell_state;
    logic applied;
  } outcome_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic [2:0] command = CMD_READ;
  logic [5:0] row = '0;
  logic [5:0] column = '0;
  logic       value = 1'b0;
  logic       done;
  logic       cell_state;
  logic       applied;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data = 1'b0;

  // Grid model, run setting and results still to come back from the block.
  logic [COLS-1:0] life_grid [ROWS];
  logic            run_allowed = 1'b0;
  outcome_t        awaited_outcomes [$];
  int              failures = 0;

  script_row_t directed_script [26] = '{
    '{DO_COMMAND, CMD_READ,   6'd0,  6'd0,  1'b0, 1'b1, 1'b0, 1'b1},
    '{DO_COMMAND, CMD_READ,   6'd63, 6'd63, 1'b1, 1'b1, 1'b0, 1'b1},
    '{DO_COMMAND, CMD_STEP,   6'd0,  6'd0,  1'b0, 1'b1, 1'b0, 1'b0},
    '{DO_COMMAND, CMD_SET,    6'd0,  6'd0,  1'b1, 1'b1, 1'b1, 1'b1},
    '{DO_COMMAND, CMD_SET,    6'd63, 6'd63, 1'b1, 1'b1, 1'b1, 1'b1},
    '{DO_COMMAND, CMD_TOGGLE, 6'd63, 6'd0,  1'b0, 1'b1, 1'b1, 1'b1},
    '{DO_COMMAND, CMD_TOGGLE, 6'd63, 6'd0,  1'b1, 1'b1, 1'b0, 1'b1},
    '{DO_COMMAND, CMD_SET,    6'd63, 6'd63, 1'b0, 1'b1, 1'b0, 1'b1},
    '{DO_COMMAND, CMD_CLEAR,  6'd63, 6'd63, 1'b1, 1'b1, 1'b0, 1'b1},
    '{DO_COMMAND, CMD_READ,   6'd0,  6'd0,  1'b0, 1'b1, 1'b0, 1'b1},
    '{DO_COMMAND, CMD_BAD_5,  6'd63, 6'd63, 1'b1, 1'b1, 1'b0, 1'b0},
    '{DO_COMMAND, CMD_BAD_6,  6'd21, 6'd42, 1'b0, 1'b1, 1'b0, 1'b0},
    '{DO_COMMAND, CMD_BAD_7,  6'd42, 6'd21, 1'b1, 1'b1, 1'b0, 1'b0},
    '{DO_COMMAND, CMD_SET,    6'd0,  6'd63, 1'b1, 1'b1, 1'b1, 1'b1},
    '{DO_COMMAND, CMD_SET,    6'd0,  6'd0,  1'b1, 1'b1, 1'b1, 1'b1},
    '{DO_COMMAND, CMD_SET,    6'd0,  6'd1,  1'b1, 1'b1, 1'b1, 1'b1},
    '{DO_CONFIG,  CMD_READ,   6'd0,  6'd0,  1'b1, 1'b0, 1'b0, 1'b0},
    '{DO_COMMAND, CMD_CLEAR,  6'd0,  6'd0,  1'b0, 1'b1, 1'b0, 1'b0},
    '{DO_COMMAND, CMD_STEP,   6'd0,  6'd0,  1'b0, 1'b1, 1'b0, 1'b1},
    '{DO_COMMAND, CMD_READ,   6'd63, 6'd0,  1'b0, 1'b0, 1'b0, 1'b0},
    '{DO_COMMAND, CMD_READ,   6'd1,  6'd0,  1'b0, 1'b0, 1'b0, 1'b0},
    '{DO_COMMAND, CMD_READ,   6'd0,  6'd63, 1'b0, 1'b0, 1'b0, 1'b0},
    '{DO_COMMAND, CMD_STEP,   6'd0,  6'd0,  1'b0, 1'b1, 1'b0, 1'b1},
    '{DO_COMMAND, CMD_READ,   6'd0,  6'd1,  1'b0, 1'b0, 1'b0, 1'b0},
    '{DO_CONFIG,  CMD_READ,   6'd0,  6'd0,  1'b0, 1'b0, 1'b0, 1'b0},
    '{DO_COMMAND, CMD_CLEAR,  6'd5,  6'd9,  1'b0, 1'b1, 1'b0, 1'b1}
  };

  life_cellular_automaton_torus_core #(
    .GRID_ROWS(ROWS),
    .GRID_COLS(COLS)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .command   (command),
    .row       (row),
    .column    (column),
    .value     (value),
    .done      (done),
    .cell_state(cell_state),
    .applied   (applied),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Count of live cells among the eight neighbors, with wrap on both axes.
  function automatic int live_neighbors(input int r, input int c);
    int up;
    int dn;
    int lf;
    int rt;
    up = (r + ROWS - 1) % ROWS;
    dn = (r + 1) % ROWS;
    lf = (c + COLS - 1) % COLS;
    rt = (c + 1) % COLS;
    return life_grid[up][lf] + life_grid[up][c] + life_grid[up][rt]
         + life_grid[r][lf] + life_grid[r][rt]
         + life_grid[dn][lf] + life_grid[dn][c] + life_grid[dn][rt];
  endfunction

  // All cells move to the next generation at once, from the old grid.
  task automatic advance_generation();
    logic [COLS-1:0] next_rows [ROWS];
    int              n;
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        n = live_neighbors(r, c);
        if (life_grid[r][c])
          next_rows[r][c] = (n == LIFE_SURVIVE) || (n == LIFE_BIRTH);
        else
          next_rows[r][c] = (n == LIFE_BIRTH);
      end
    end
    for (int r = 0; r < ROWS; r++) life_grid[r] = next_rows[r];
  endtask

  // Applies one accepted command to the grid model and gives its result.
  task automatic model_command(input logic [2:0] cmd, input logic [5:0] r,
                               input logic [5:0] c, input logic v,
                               output logic st, output logic ap);
    st = 1'b0;
    ap = 1'b0;
    case (cmd)
      CMD_SET, CMD_TOGGLE, CMD_READ: begin
        if (r < ROWS && c < COLS) begin
          if (cmd == CMD_SET) life_grid[r][c] = v;
          else if (cmd == CMD_TOGGLE) life_grid[r][c] = ~life_grid[r][c];
          st = life_grid[r][c];
          ap = 1'b1;
        end
      end
      CMD_CLEAR: begin
        if (!run_allowed) begin
          for (int i = 0; i < ROWS; i++) life_grid[i] = '0;
          ap = 1'b1;
        end
      end
      CMD_STEP: begin
        if (run_allowed) begin
          advance_generation();
          ap = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  // Presents one command and waits for its transfer. start stays high on
  // return so that a following command can go out without a gap.
  task automatic issue_command(input logic [2:0] cmd, input logic [5:0] r,
                               input logic [5:0] c, input logic v,
                               input logic typed, input logic exp_state,
                               input logic exp_applied);
    logic     st;
    logic     ap;
    outcome_t want;
    start   <= 1'b1;
    command <= cmd;
    row     <= r;
    column  <= c;
    value   <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    model_command(cmd, r, c, v, st, ap);
    want.cell_state = typed ? exp_state : st;
    want.applied    = typed ? exp_applied : ap;
    awaited_outcomes.push_back(want);
  endtask

  // Random gap between commands, with junk on the command fields.
  task automatic maybe_idle(input bit allowed);
    if (allowed && $urandom_range(0, 99) < 19) begin
      start   <= 1'b0;
      command <= 3'($urandom);
      row     <= 6'($urandom);
      column  <= 6'($urandom);
      value   <= 1'($urandom);
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(10, 90)) @(posedge clk);
      else repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Writes run_enabled once the block has drained all outstanding commands.
  task automatic write_run_enable(input logic setting);
    start <= 1'b0;
    while (awaited_outcomes.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= setting;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid   <= 1'b0;
    run_allowed = setting;
  endtask

  // Result checker: every done pulse is matched against the oldest expectation.
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && done) begin
      if (awaited_outcomes.size() == 0) begin
        $error("unexpected result: cell_state=%0b applied=%0b", cell_state, applied);
        failures++;
      end else begin
        want = awaited_outcomes.pop_front();
        if (cell_state !== want.cell_state) begin
          $error("cell_state mismatch: expected %0b, got %0b", want.cell_state, cell_state);
          failures++;
        end
        if (applied !== want.applied) begin
          $error("applied mismatch: expected %0b, got %0b", want.applied, applied);
          failures++;
        end
      end
    end
  end

  // Stimulus: reset, the directed table, then random phases.
  initial begin
    logic [2:0] cmd;
    logic [5:0] r;
    logic [5:0] c;
    logic [5:0] spot_r;
    logic [5:0] spot_c;
    int         pick;
    bit         idle_on;
    for (int i = 0; i < ROWS; i++) life_grid[i] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_script[i]) begin
      if (directed_script[i].kind == DO_CONFIG) begin
        write_run_enable(directed_script[i].v);
      end else begin
        issue_command(directed_script[i].cmd, directed_script[i].r, directed_script[i].c,
                      directed_script[i].v, directed_script[i].typed,
                      directed_script[i].exp_state, directed_script[i].exp_applied);
        maybe_idle(1'b1);
      end
    end

    // Each phase fixes run_enabled and a spot where most cell writes land,
    // so that patterns dense enough to evolve build up around it.
    for (int p = 0; p < PHASES; p++) begin
      write_run_enable((p % 3) != 1);
      spot_r  = 6'($urandom);
      spot_c  = 6'($urandom);
      idle_on = (p != 3);
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 24) cmd = CMD_SET;
        else if (pick < 38) cmd = CMD_TOGGLE;
        else if (pick < 64) cmd = CMD_READ;
        else if (pick < 82) cmd = CMD_STEP;
        else if (pick < 89) cmd = CMD_CLEAR;
        else cmd = 3'($urandom_range(CMD_BAD_5, CMD_BAD_7));
        if ($urandom_range(0, 3) != 0) begin
          r = spot_r + 6'($urandom_range(0, 5)) - 6'd2;
          c = spot_c + 6'($urandom_range(0, 5)) - 6'd2;
        end else begin
          r = 6'($urandom);
          c = 6'($urandom);
        end
        issue_command(cmd, r, c, 1'($urandom_range(0, 2) != 0), 1'b0, 1'b0, 1'b0);
        maybe_idle(idle_on);
      end
    end

    start <= 1'b0;
    while (awaited_outcomes.size() != 0) @(posedge clk);
    repeat (STEP_CYCLES + 8) @(posedge clk);
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #10ms;
    $display("Verification failed");
    $finish;
  end

endmodule
